[rtl/bfbp_pkg.sv]
// Shared types and codes of the best-fit buffer pool.
package bfbp_pkg;

    localparam int REQ_SIZE_W = 24;
    localparam int HANDLE_W   = 4;
    localparam int STATUS_W   = 2;
    localparam int ACTION_W   = 2;
    localparam int CFG_W      = 5;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_DONE     = 2'd0,
        ST_BUSY     = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [ACTION_W-1:0]
    {
        ACT_REUSE  = 2'd0,
        ACT_RESIZE = 2'd1,
        ACT_CREATE = 2'd2
    } action_t;

    typedef struct packed
    {
        logic                  operation;
        logic [REQ_SIZE_W-1:0] request_size;
        logic [HANDLE_W-1:0]   handle;
    } bfbp_req_t;

    typedef struct packed
    {
        logic [STATUS_W-1:0]   status;
        logic [HANDLE_W-1:0]   granted_slot;
        logic [ACTION_W-1:0]   action;
        logic [REQ_SIZE_W-1:0] granted_size;
    } bfbp_rsp_t;

endpackage

[rtl/bfbp_req_if.sv]
// Request channel of the buffer pool: valid, ready and the request payload.
interface bfbp_req_if;
    import bfbp_pkg::*;

    logic      valid;
    logic      ready;
    bfbp_req_t payload;

    modport source
    (
        output valid,
        output payload,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  payload,
        output ready
    );
endinterface

[rtl/bfbp_rsp_if.sv]
// Response channel of the buffer pool: valid, ready and the response payload.
interface bfbp_rsp_if;
    import bfbp_pkg::*;

    logic      valid;
    logic      ready;
    bfbp_rsp_t payload;

    modport source
    (
        output valid,
        output payload,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  payload,
        output ready
    );
endinterface

[rtl/bfbp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module bfbp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/best_fit_buffer_pool.sv]
// Best-fit buffer pool: top level with slot-size RAM, lock bits and scan sequencer.
//
// Requests arrive on req (valid/ready) and carry an operation, a size and a
// handle. Every request yields exactly one response on rsp, in order.
// An allocate request scans the existing slots through the slot-size RAM, one
// slot read per cycle, then decides in the decision step, writing the size back
// on a resize or create; on an empty pool it goes straight to the decision step.
// A free request goes to the free step. The single RAM read port sets the scan
// length.
// One request is in flight at a time; req.ready is high whenever the
// sequencer is idle, even while an earlier response still waits in the
// output register. If rsp stalls, the decision or free step waits until the
// output register can be loaded, and no slot or lock state changes until then.
// The slot limit is written through cfg_we/cfg_wdata; the user must write it
// only while idle, as the block itself does not enforce this. Reset clears all
// lock bits, the slot count and the output register and sets the slot limit to
// 16; slot sizes need no clearing because only created slots are ever read.
module best_fit_buffer_pool #(
    parameter int NUM_SLOTS = 16,
    parameter int SIZE_BITS = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    bfbp_req_if.sink                   req,
    bfbp_rsp_if.source                 rsp,
    input  logic                       cfg_we,
    input  logic [bfbp_pkg::CFG_W-1:0] cfg_wdata
);
    import bfbp_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;
    localparam int HW = (CW > HANDLE_W) ? CW : HANDLE_W;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FREE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       max_buf_reg, max_buf_next;
    logic [NUM_SLOTS-1:0]   locked_reg, locked_next;
    logic [CW-1:0]          in_use_reg, in_use_next;
    logic [SIZE_BITS-1:0]   size_reg, size_next;
    logic [HANDLE_W-1:0]    handle_reg, handle_next;
    logic [CW-1:0]          issue_reg, issue_next;
    logic [IW-1:0]          eval_reg, eval_next;
    logic                   found_reg, found_next;
    logic [IW-1:0]          best_reg, best_next;
    logic [SIZE_BITS-1:0]   best_size_reg, best_size_next;
    logic                   any_free_reg, any_free_next;
    logic [IW-1:0]          first_free_reg, first_free_next;
    logic                   out_valid_reg, out_valid_next;
    bfbp_rsp_t              out_reg, out_next;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic                   ram_re;
    logic [IW-1:0]          ram_raddr;
    logic [SIZE_BITS-1:0]   ram_rdata;

    logic                   accept;
    logic                   out_free;
    logic                   slot_unlocked;
    logic                   slot_fits;
    logic                   create_ok;
    logic                   free_ok;
    logic [IW-1:0]          grant_idx;
    logic [SIZE_BITS-1:0]   req_size;

    bfbp_ram #(
        .WIDTH(SIZE_BITS),
        .DEPTH(NUM_SLOTS)
    ) u_size_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(size_reg),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign req.ready   = (state_reg == S_IDLE);
    assign accept      = req.valid && req.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;
    assign req_size    = SIZE_BITS'(req.payload.request_size);

    assign slot_unlocked = !locked_reg[eval_reg];
    assign slot_fits     = (ram_rdata >= size_reg);
    // An empty pool always gets slot 0, whatever the limit says.
    assign create_ok = ((in_use_reg == '0) || (LW'(in_use_reg) < LW'(max_buf_reg)))
                       && (in_use_reg < CW'(NUM_SLOTS));
    assign free_ok   = (HW'(handle_reg) < HW'(in_use_reg));

    always_comb
    begin
        state_next      = state_reg;
        max_buf_next    = cfg_we ? cfg_wdata : max_buf_reg;
        locked_next     = locked_reg;
        in_use_next     = in_use_reg;
        size_next       = size_reg;
        handle_next     = handle_reg;
        issue_next      = issue_reg;
        eval_next       = eval_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_size_next  = best_size_reg;
        any_free_next   = any_free_reg;
        first_free_next = first_free_reg;
        out_valid_next  = rsp.ready ? 1'b0 : out_valid_reg;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        grant_idx       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    size_next     = req_size;
                    handle_next   = req.payload.handle;
                    found_next    = 1'b0;
                    any_free_next = 1'b0;
                    if (req.payload.operation == OP_FREE)
                    begin
                        state_next = S_FREE;
                    end
                    else if (in_use_reg == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        // Slot 0 is read now; its data is judged in the first scan cycle.
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        eval_next  = '0;
                        issue_next = CW'(1);
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (slot_unlocked && slot_fits && (!found_reg || (ram_rdata < best_size_reg)))
                begin
                    found_next     = 1'b1;
                    best_next      = eval_reg;
                    best_size_next = ram_rdata;
                end
                if (slot_unlocked && !any_free_reg)
                begin
                    any_free_next   = 1'b1;
                    first_free_next = eval_reg;
                end
                if (issue_reg < in_use_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = issue_reg[IW-1:0];
                    eval_next  = issue_reg[IW-1:0];
                    issue_next = issue_reg + CW'(1);
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    out_next       = '0;
                    if (found_reg)
                    begin
                        grant_idx             = best_reg;
                        out_next.action       = ACT_REUSE;
                        out_next.granted_size = REQ_SIZE_W'(best_size_reg);
                    end
                    else if (any_free_reg)
                    begin
                        grant_idx             = first_free_reg;
                        ram_we                = 1'b1;
                        out_next.action       = ACT_RESIZE;
                        out_next.granted_size = REQ_SIZE_W'(size_reg);
                    end
                    else if (create_ok)
                    begin
                        grant_idx             = in_use_reg[IW-1:0];
                        ram_we                = 1'b1;
                        in_use_next           = in_use_reg + CW'(1);
                        out_next.action       = ACT_CREATE;
                        out_next.granted_size = REQ_SIZE_W'(size_reg);
                    end
                    ram_waddr = grant_idx;
                    if (found_reg || any_free_reg || create_ok)
                    begin
                        locked_next[grant_idx] = 1'b1;
                        out_next.status        = ST_DONE;
                        out_next.granted_slot  = HANDLE_W'(grant_idx);
                    end
                    else
                    begin
                        out_next.status = ST_BUSY;
                    end
                end
            end

            S_FREE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    out_next       = '0;
                    if (free_ok)
                    begin
                        locked_next[IW'(handle_reg)] = 1'b0;
                        out_next.status              = ST_DONE;
                    end
                    else
                    begin
                        out_next.status = ST_BAD_FREE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_buf_reg    <= LIMIT_RESET;
            locked_reg     <= '0;
            in_use_reg     <= '0;
            size_reg       <= '0;
            handle_reg     <= '0;
            issue_reg      <= '0;
            eval_reg       <= '0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            best_size_reg  <= '0;
            any_free_reg   <= 1'b0;
            first_free_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            max_buf_reg    <= max_buf_next;
            locked_reg     <= locked_next;
            in_use_reg     <= in_use_next;
            size_reg       <= size_next;
            handle_reg     <= handle_next;
            issue_reg      <= issue_next;
            eval_reg       <= eval_next;
            found_reg      <= found_next;
            best_reg       <= best_next;
            best_size_reg  <= best_size_next;
            any_free_reg   <= any_free_next;
            first_free_reg <= first_free_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end
endmodule

[rtl/bfbp_checker.sv]
// Port-level checker of the buffer pool and its bind to the top level.
module bfbp_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  bfbp_pkg::bfbp_rsp_t rsp_payload
);
    import bfbp_pkg::*;

    // A stalled response keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("response changed while stalled");

    // Only one request is in flight: the block is busy right after accepting one.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("second request accepted while one is in flight");

    // A new response only appears after the sequencer has been working.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
    else $error("response without a request in progress");

    // Refused requests and unknown-slot frees carry action field zero, the code of ACT_REUSE.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.status != ST_DONE |-> rsp_payload.action == ACT_REUSE)
    else $error("action set on an error response");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.status != ST_DONE
        |-> rsp_payload.granted_slot == '0 && rsp_payload.granted_size == '0)
    else $error("nonzero grant on an error response");
endmodule

bind best_fit_buffer_pool bfbp_checker u_bfbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_payload(rsp.payload)
);
